// ----- design/double_ended_queue_macros.svh -----
// Assertion helpers for the deque block.
// Each macro takes a label, clock, active-low reset, a trigger and a check.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check holds in the same cycle as the trigger.
`define DEQ_ASSERT_SAME(label, clk, rst_n, trig, chk) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (chk)) \
        else $error("deque assertion failed");

// Check holds in the cycle after the trigger.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, trig, chk) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (chk)) \
        else $error("deque assertion failed");

`endif

// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int PUSH_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // take the request on the input channel
        logic load;     // move the finished result into the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- design/deq_if.sv -----
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for deque requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic                     at_rear;
    logic signed [PUSH_W-1:0] push_value;

    modport source (output valid, output operation, output at_rear, output push_value,
                    input ready);
    modport sink   (input valid, input operation, input at_rear, input push_value,
                    output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PUSH_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output popped_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ----- design/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Two-state controller: take a request, then hand its result to the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output deq_pkg::t_dp_cmd o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_out_stall;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_stall = (r_state == S_LOAD) && r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            S_LOAD: begin
                o_cmd.load = w_out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;

    `DEQ_ASSERT_NEXT(a_accept_to_load, i_clk, i_rst_n, o_cmd.accept, r_state == S_LOAD)
    `DEQ_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load, r_out_valid)
    `DEQ_ASSERT_NEXT(a_stall_holds_load, i_clk, i_rst_n, w_out_stall, r_state == S_LOAD)

endmodule

`default_nettype wire

// ----- design/deq_dp.sv -----
// ----------------------------------------------------------------------------
// deq_dp
// Ring store, front pointer, word count and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_dp #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  deq_pkg::t_dp_cmd                         i_cmd,
    input  wire                                      i_operation,
    input  wire                                      i_at_rear,
    input  wire  signed [deq_pkg::PUSH_W-1:0]        i_push_value,
    output logic signed [deq_pkg::PUSH_W-1:0]        o_popped_value,
    output logic        [deq_pkg::STATUS_W-1:0]      o_status,
    output logic        [deq_pkg::OCC_W-1:0]         o_occupancy
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [PTR_W-1:0] r_front;
    logic [PTR_W-1:0] n_front;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_pend_status;
    logic             r_pend_rd;

    logic [PTR_W-1:0] w_slot;
    logic [SUM_W-1:0] w_rear_sum;
    logic [PTR_W-1:0] w_front_dec;
    logic [PTR_W-1:0] w_front_inc;
    logic             w_full;
    logic             w_empty;
    logic             w_remove;
    logic             w_do_write;
    logic             w_do_read;
    t_status          w_status;

    function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
        if (s >= SUM_W'(DEPTH)) return PTR_W'(s - SUM_W'(DEPTH));
        else return PTR_W'(s);
    endfunction

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_remove = (i_operation == OP_REMOVE);

    // rear slot: front + count for insert, front + count - 1 for removal
    assign w_rear_sum  = {1'b0, r_front} + SUM_W'(r_count) - SUM_W'(w_remove);
    assign w_front_dec = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - 1'b1;
    assign w_front_inc = (r_front == PTR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    always_comb begin
        if (i_at_rear) w_slot = wrap(w_rear_sum);
        else if (w_remove) w_slot = r_front;
        else w_slot = w_front_dec;
    end

    assign w_do_write = i_cmd.accept && !w_remove && !w_full;
    assign w_do_read  = i_cmd.accept && w_remove && !w_empty;

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        w_status = ST_DONE;
        if (!w_remove) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
                if (!i_at_rear) n_front = w_front_dec;
            end
        end else begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                if (!i_at_rear) n_front = w_front_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // ring store, at most one write or one registered read per request
    always_ff @(posedge i_clk) begin
        if (w_do_write) r_mem[w_slot] <= WORD_BITS'($unsigned(i_push_value));
        if (w_do_read) r_rd_data <= r_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_status <= w_status;
            r_pend_rd     <= w_do_read;
        end
        if (i_cmd.load) begin
            o_popped_value <= r_pend_rd ? $signed(PUSH_W'($unsigned(r_rd_data))) : '0;
            o_status       <= r_pend_status;
            o_occupancy    <= OCC_W'(r_count);
        end
    end

    `DEQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `DEQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_do_write, r_count == $past(r_count) + 1'b1)
    `DEQ_ASSERT_NEXT(a_refused_keeps, i_clk, i_rst_n, i_cmd.accept && (w_status != ST_DONE), $stable(r_count) && $stable(r_front))

endmodule

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// Order: a request is taken in IDLE, where the ring is written or its word read into
//   a register; in LOAD the response is registered; a stalled response holds requests.
// Flow: a new request is not taken until the last one's result is loaded, set by the
//   ring memory that sits between accepting a request and loading its result.
// Reset: synchronous, active low; the queue comes up empty with the front
//   pointer at slot 0, no request is taken during reset, memory is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of words in a circular store, insert/remove at either end.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);
    import deq_pkg::*;

    // controller -> datapath commands
    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    // Controller: IDLE takes a transaction, LOAD waits until the output
    // register is empty or being drained, then hands the result over.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: ring memory indexed from the front pointer and count.
    // Wrap-around uses a compare-and-subtract so DEPTH need not be 2^n.
    deq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_operation    (i_req.operation),
        .i_at_rear      (i_req.at_rear),
        .i_push_value   (i_req.push_value),
        .o_popped_value (o_rsp.popped_value),
        .o_status       (o_rsp.status),
        .o_occupancy    (o_rsp.occupancy)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

`default_nettype wire
